// File: design/lmts_pkg.sv
// Shared types and constants for the LCD mode timing sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lmts_pkg;

    // Countdown and operand widths
    localparam int CountW   = 12;
    localparam int OperandW = 13;

    // Scan timing constants
    localparam logic [7:0] VisibleLines = 8'd144;
    localparam logic [7:0] TotalLines   = 8'd154;
    localparam logic [7:0] LastVisible  = 8'd143;
    localparam logic [7:0] WrapLine     = 8'd255;

    localparam logic signed [OperandW-1:0] LineCycles   = 13'sd456;
    localparam logic signed [OperandW-1:0] OamCycles    = 13'sd80;
    localparam logic signed [OperandW-1:0] DrawCycles   = 13'sd172;
    localparam logic signed [OperandW-1:0] HblankCycles = 13'sd204;
    localparam logic signed [OperandW-1:0] NoCycles     = 13'sd0;

    // Events per tick; the counter indexes 0 .. MaxEvents-1
    localparam int MaxEvents = 16;
    localparam int EvtCntW   = $clog2(MaxEvents);
    localparam logic [EvtCntW-1:0] LastEventIdx = EvtCntW'(MaxEvents - 1);

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } lcd_mode_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_STEP = 1'b1
    } seq_state_t;

    typedef struct packed {
        logic [9:0] elapsed;
        logic       draw_enable;
        logic       display_on;
        logic [7:0] compare_line;
    } tick_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic       coincidence;
        logic       vbl_irq;
        logic       stat_irq;
        logic       draw_request;
        logic       frame_end;
        logic       frame_begin;
        logic       last;
    } evt_t;

endpackage

`default_nettype wire

// File: design/lmts_cd_alu.sv
// Shared countdown adder with saturation to the 12-bit signed range.
// Depends on lmts_pkg for widths.
`default_nettype none

module lmts_cd_alu (
    input  wire logic signed [lmts_pkg::CountW-1:0]   countdown,
    input  wire logic signed [lmts_pkg::OperandW-1:0] operand,
    output logic signed [lmts_pkg::CountW-1:0]        result
);

    localparam logic signed [lmts_pkg::OperandW-1:0] MinVal =
        -(lmts_pkg::OperandW'(1) <<< (lmts_pkg::CountW - 1));
    localparam logic signed [lmts_pkg::OperandW-1:0] MaxVal =
        (lmts_pkg::OperandW'(1) <<< (lmts_pkg::CountW - 1)) - lmts_pkg::OperandW'(1);

    logic signed [lmts_pkg::OperandW-1:0] sum;

    // Add in one extra bit, then saturate
    always_comb
    begin
        sum = lmts_pkg::OperandW'(countdown) + operand;
        if (sum < MinVal)
        begin
            result = lmts_pkg::CountW'(MinVal);
        end
        else if (sum > MaxVal)
        begin
            result = lmts_pkg::CountW'(MaxVal);
        end
        else
        begin
            result = sum[lmts_pkg::CountW-1:0];
        end
    end

endmodule

`default_nettype wire

// File: design/lcd_mode_timing_sequencer_core.sv
// LCD mode timing sequencer, top level: step sequencer, scan state and output register.
// Depends on lmts_pkg and lmts_cd_alu.
//
// Usage:
//   tick channel (tick_valid / tick_stall / tick): one transfer per tick, carrying
//   the elapsed cycles, draw enable, display-on bit and line-compare value.
//   evt channel (evt_valid / evt_stall / evt): one transfer per step (a mode change
//   or a new vblank line); the final event of a tick has last set. A tick that
//   leaves the countdown non-negative produces no event.
// Timing: the tick is loaded into the countdown at the transfer edge; after that
//   the shared countdown adder takes one step per cycle while the event register
//   can take an event, so a tick yields k events (k at most 16). The first event
//   is registered: the step state follows the tick transfer, then the event register.
//   tick_stall is high while the sequencer is in its step state.
// The event register frees the sequencer: the next tick is taken while the last
//   event of the previous one still waits. When evt_stall is high and the
//   register is full, stepping pauses; nothing is dropped.
// Reset (rst_n low, asynchronous): mode hblank, line 0, countdown 0, match flag
//   clear, no event pending.
`default_nettype none

module lcd_mode_timing_sequencer_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            tick_valid,
    output logic                 tick_stall,
    input  wire lmts_pkg::tick_t tick,
    output logic                 evt_valid,
    input  wire logic            evt_stall,
    output lmts_pkg::evt_t       evt
);

    lmts_pkg::seq_state_t state_reg, state_next;
    logic signed [lmts_pkg::CountW-1:0]   countdown_reg;
    logic signed [lmts_pkg::CountW-1:0]   alu_result;
    logic signed [lmts_pkg::OperandW-1:0] alu_operand;
    lmts_pkg::lcd_mode_t          mode_reg, mode_step;
    logic [7:0]                   line_reg, line_step, line_inc;
    logic                         match_reg, match_step;
    logic [lmts_pkg::EvtCntW-1:0] cnt_reg;
    lmts_pkg::tick_t              tick_reg;
    lmts_pkg::evt_t               evt_reg, evt_step;
    logic                         evt_valid_reg;
    logic signed [lmts_pkg::OperandW-1:0] step_cycles;
    logic tick_xfer, slot_free, pending, do_step, step_last;

    assign tick_xfer = tick_valid && !tick_stall;
    assign slot_free = !evt_valid_reg || !evt_stall;
    assign pending   = countdown_reg[lmts_pkg::CountW-1];

    // Shared countdown adder
    lmts_cd_alu u_alu (
        .countdown (countdown_reg),
        .operand   (alu_operand),
        .result    (alu_result)
    );

    // Next mode, line and flags for one step
    always_comb
    begin
        line_inc   = line_reg + 8'd1;
        mode_step  = mode_reg;
        line_step  = line_reg;
        match_step = match_reg;
        step_cycles = lmts_pkg::NoCycles;
        evt_step   = '0;
        case (mode_reg)
            lmts_pkg::MODE_HBLANK:
            begin
                line_step = line_inc;
                if (line_inc == lmts_pkg::VisibleLines)
                begin
                    evt_step.vbl_irq = tick_reg.display_on;
                    mode_step   = lmts_pkg::MODE_VBLANK;
                    match_step  = 1'b0;
                    step_cycles = lmts_pkg::LineCycles;
                end
                else
                begin
                    mode_step   = lmts_pkg::MODE_OAM;
                    step_cycles = lmts_pkg::OamCycles;
                end
                if (line_inc == tick_reg.compare_line && tick_reg.display_on)
                begin
                    match_step        = 1'b1;
                    evt_step.stat_irq = 1'b1;
                end
            end
            lmts_pkg::MODE_VBLANK:
            begin
                if (line_inc == lmts_pkg::TotalLines)
                begin
                    evt_step.frame_begin = 1'b1;
                    mode_step   = lmts_pkg::MODE_HBLANK;
                    line_step   = lmts_pkg::WrapLine;
                    step_cycles = lmts_pkg::NoCycles;
                end
                else
                begin
                    line_step   = line_inc;
                    step_cycles = lmts_pkg::LineCycles;
                end
            end
            lmts_pkg::MODE_OAM:
            begin
                mode_step   = lmts_pkg::MODE_DRAW;
                step_cycles = lmts_pkg::DrawCycles;
            end
            default:
            begin
                mode_step   = lmts_pkg::MODE_HBLANK;
                step_cycles = lmts_pkg::HblankCycles;
                evt_step.draw_request = tick_reg.draw_enable;
                evt_step.frame_end    = (line_reg == lmts_pkg::LastVisible);
            end
        endcase
        step_last            = !alu_result[lmts_pkg::CountW-1] ||
                               (cnt_reg == lmts_pkg::LastEventIdx);
        evt_step.mode        = mode_step;
        evt_step.line        = line_step;
        evt_step.coincidence = match_step;
        evt_step.last        = step_last;
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmts_pkg::SEQ_IDLE:
            begin
                if (tick_valid)
                begin
                    state_next = lmts_pkg::SEQ_STEP;
                end
            end
            lmts_pkg::SEQ_STEP:
            begin
                if (!pending || (slot_free && step_last))
                begin
                    state_next = lmts_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = lmts_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs: stall, adder operand, step strobe
    always_comb
    begin
        tick_stall  = 1'b1;
        do_step     = 1'b0;
        alu_operand = lmts_pkg::NoCycles;
        case (state_reg)
            lmts_pkg::SEQ_IDLE:
            begin
                tick_stall  = 1'b0;
                alu_operand = -lmts_pkg::OperandW'(tick.elapsed);
            end
            lmts_pkg::SEQ_STEP:
            begin
                do_step     = pending && slot_free;
                alu_operand = step_cycles;
            end
            default:
            begin
                tick_stall = 1'b1;
            end
        endcase
    end

    // Control and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmts_pkg::SEQ_IDLE;
            countdown_reg <= '0;
            mode_reg      <= lmts_pkg::MODE_HBLANK;
            line_reg      <= '0;
            match_reg     <= 1'b0;
            cnt_reg       <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (tick_xfer)
            begin
                countdown_reg <= alu_result;
                cnt_reg       <= '0;
            end
            else if (do_step)
            begin
                countdown_reg <= alu_result;
                mode_reg      <= mode_step;
                line_reg      <= line_step;
                match_reg     <= match_step;
                cnt_reg       <= cnt_reg + lmts_pkg::EvtCntW'(1);
            end
            if (do_step)
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (!evt_stall)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    // Tick fields and event payload
    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            tick_reg <= tick;
        end
        if (do_step)
        begin
            evt_reg <= evt_step;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

`default_nettype wire

// File: design/lmts_checker.sv
// Port-level checks for the LCD mode timing sequencer, and their bind to the top level.
// Depends on lmts_pkg and lcd_mode_timing_sequencer_core.
`default_nettype none

module lmts_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            tick_valid,
    input wire logic            tick_stall,
    input wire logic            evt_valid,
    input wire logic            evt_stall,
    input wire lmts_pkg::evt_t  evt
);

    // Busy in the cycle after a tick transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall) |=> tick_stall)
        else $error("tick taken on the cycle after a tick transfer");

    // A pending non-final event means the tick is still being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt.last) |-> tick_stall)
        else $error("new tick possible before the final event");

    // Stalled event holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_stall) |=> (evt_valid && $stable(evt)))
        else $error("stalled event changed");

    // Frame begin only on the wrap marker
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt.frame_begin) |->
            (evt.mode == lmts_pkg::MODE_HBLANK && evt.line == lmts_pkg::WrapLine))
        else $error("frame begin without wrap line");

    // Vblank interrupt only on entry to vblank at the first blank line
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt.vbl_irq) |->
            (evt.mode == lmts_pkg::MODE_VBLANK && evt.line == lmts_pkg::VisibleLines))
        else $error("vblank interrupt outside vblank entry");

endmodule

bind lcd_mode_timing_sequencer_core lmts_checker u_lmts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .evt        (evt)
);

`default_nettype wire

// File: tb/sv/tb_lcd_mode_timing_sequencer_core.sv
// Testbench for lcd_mode_timing_sequencer_core: drives ticks, predicts mode events
// and checks every event transfer. Depends on lmts_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_lcd_mode_timing_sequencer_core;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 40;
    localparam int HoldOffCycles = 250;

    logic            clk;
    logic            rst_n      = 1'b0;
    logic            tick_valid = 1'b0;
    logic            tick_stall;
    lmts_pkg::tick_t tick       = '0;
    logic            evt_valid;
    logic            evt_stall  = 1'b0;
    lmts_pkg::evt_t  evt;

    // Scan state as the testbench tracks it
    lmts_pkg::lcd_mode_t model_mode      = lmts_pkg::MODE_HBLANK;
    logic [7:0]          model_line      = 8'd0;
    int                  model_countdown = 0;
    logic                model_match     = 1'b0;

    lmts_pkg::evt_t pending_events[$];
    int   errors       = 0;
    int   idle_cycles  = 0;
    bit   steady       = 1'b0;
    int   hold_request = 0;
    int   hold_left    = 0;

    lcd_mode_timing_sequencer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt        (evt)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int clamp_countdown(input int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    function automatic lmts_pkg::tick_t mk_tick(input int el, input bit den, input bit don,
                                                input int cmp);
        lmts_pkg::tick_t t;
        t.elapsed      = 10'(el);
        t.draw_enable  = den;
        t.display_on   = don;
        t.compare_line = 8'(cmp);
        return t;
    endfunction

    // Step the scan state through one tick and queue the events it causes
    task automatic advance_scan(input lmts_pkg::tick_t t);
        int             n;
        bit             have_prev;
        lmts_pkg::evt_t prev;
        lmts_pkg::evt_t e;
        n         = 0;
        have_prev = 1'b0;
        prev      = '0;
        model_countdown = clamp_countdown(model_countdown - int'(t.elapsed));
        while (model_countdown < 0 && n < lmts_pkg::MaxEvents)
        begin
            e = '0;
            case (model_mode)
                lmts_pkg::MODE_HBLANK:
                begin
                    model_line = model_line + 8'd1;
                    if (model_line == lmts_pkg::VisibleLines)
                    begin
                        e.vbl_irq    = t.display_on;
                        model_mode   = lmts_pkg::MODE_VBLANK;
                        model_match  = 1'b0;
                        model_countdown += int'(lmts_pkg::LineCycles);
                    end
                    else
                    begin
                        model_mode = lmts_pkg::MODE_OAM;
                        model_countdown += int'(lmts_pkg::OamCycles);
                    end
                    if (model_line == t.compare_line && t.display_on)
                    begin
                        model_match = 1'b1;
                        e.stat_irq  = 1'b1;
                    end
                end
                lmts_pkg::MODE_VBLANK:
                begin
                    model_line = model_line + 8'd1;
                    if (model_line == lmts_pkg::TotalLines)
                    begin
                        // frame wraps: no cycles added, next step follows at once
                        e.frame_begin = 1'b1;
                        model_mode    = lmts_pkg::MODE_HBLANK;
                        model_line    = lmts_pkg::WrapLine;
                    end
                    else
                        model_countdown += int'(lmts_pkg::LineCycles);
                end
                lmts_pkg::MODE_OAM:
                begin
                    model_mode = lmts_pkg::MODE_DRAW;
                    model_countdown += int'(lmts_pkg::DrawCycles);
                end
                default:
                begin
                    model_mode     = lmts_pkg::MODE_HBLANK;
                    model_countdown += int'(lmts_pkg::HblankCycles);
                    e.draw_request = t.draw_enable;
                    e.frame_end    = (model_line == lmts_pkg::LastVisible);
                end
            endcase
            model_countdown = clamp_countdown(model_countdown);
            e.mode        = model_mode;
            e.line        = model_line;
            e.coincidence = model_match;
            if (have_prev)
                pending_events.push_back(prev);
            prev      = e;
            have_prev = 1'b1;
            n++;
        end
        if (have_prev)
        begin
            prev.last = 1'b1;
            pending_events.push_back(prev);
        end
    endtask

    // Offer one tick, hold it until the transfer, then predict its events
    task automatic send_tick(input lmts_pkg::tick_t t);
        int gap;
        if (!steady && $urandom_range(0, 99) < 8)
        begin
            gap = $urandom_range(1, 6);
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        do
            @(posedge clk);
        while (tick_stall);
        advance_scan(t);
    endtask

    // Mostly long ticks so frames complete; compare lines often aimed at the next line
    function automatic lmts_pkg::tick_t random_tick();
        lmts_pkg::tick_t t;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            t.elapsed = 10'($urandom_range(600, 1023));
        else if (pick < 80)
            t.elapsed = 10'($urandom_range(0, 150));
        else
            t.elapsed = 10'($urandom);
        t.draw_enable = 1'($urandom);
        t.display_on  = ($urandom_range(0, 99) < 85);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            t.compare_line = model_line + 8'($urandom_range(0, 2));
        else if (pick < 50)
            t.compare_line = ($urandom_range(0, 1) != 0) ? lmts_pkg::VisibleLines : 8'd0;
        else
            t.compare_line = 8'($urandom);
        return t;
    endfunction

    task automatic test_directed_extremes();
        send_tick(mk_tick(0, 0, 0, 8'hFF));
        send_tick(mk_tick(1, 1, 1, 1));
        send_tick(mk_tick(1023, 1, 1, 2));
        send_tick(mk_tick(1023, 0, 0, 4));
        send_tick(mk_tick(10'h2AA, 1, 1, 8'hAA));
        send_tick(mk_tick(10'h155, 0, 1, 8'h55));
        send_tick(mk_tick(0, 1, 1, 0));
        send_tick(mk_tick(80, 1, 1, 7));
        send_tick(mk_tick(172, 0, 1, 8));
        send_tick(mk_tick(204, 1, 0, 9));
        send_tick(mk_tick(456, 1, 1, 10));
        send_tick(mk_tick(1023, 1, 1, 0));
        send_tick(mk_tick(1023, 0, 1, 144));
        send_tick(mk_tick(1, 1, 1, 255));
    endtask

    // Receiver holds off while ticks keep coming, so the block backs up
    task automatic test_output_backpressure();
        hold_request = HoldOffCycles;
        repeat (12)
            send_tick(mk_tick(1023, 1'($urandom_range(0, 1)), 1, model_line + 8'd1));
    endtask

    task automatic test_steady_stream(input int count);
        steady = 1'b1;
        repeat (count) send_tick(random_tick());
        steady = 1'b0;
    endtask

    task automatic test_random_ticks(input int count);
        repeat (count) send_tick(random_tick());
    endtask

    task automatic report_field(input string name, input int expv, input int gotv);
        if (expv != gotv)
        begin
            errors++;
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, expv, gotv);
        end
    endtask

    // Event side: random stalls, quiet during the steady stretch, long hold on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            evt_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_request > 0)
        begin
            evt_stall    <= 1'b1;
            hold_left    <= hold_request - 1;
            hold_request = 0;
        end
        else if (steady)
            evt_stall <= 1'b0;
        else
            evt_stall <= ($urandom_range(0, 99) < 8);
    end

    // Compare each event transfer with the oldest prediction
    always @(posedge clk)
    begin
        lmts_pkg::evt_t exp_evt;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (pending_events.size() == 0)
            begin
                errors++;
                $display("%0t unexpected event: expected none, actual %p", $time, evt);
            end
            else
            begin
                exp_evt = pending_events.pop_front();
                report_field("mode", exp_evt.mode, evt.mode);
                report_field("line", exp_evt.line, evt.line);
                report_field("coincidence", exp_evt.coincidence, evt.coincidence);
                report_field("vbl_irq", exp_evt.vbl_irq, evt.vbl_irq);
                report_field("stat_irq", exp_evt.stat_irq, evt.stat_irq);
                report_field("draw_request", exp_evt.draw_request, evt.draw_request);
                report_field("frame_end", exp_evt.frame_end, evt.frame_end);
                report_field("frame_begin", exp_evt.frame_begin, evt.frame_begin);
                report_field("last", exp_evt.last, evt.last);
            end
        end
    end

    // Drop the run when no transfer happens on either side for too long
    always @(posedge clk)
    begin
        if ((tick_valid && !tick_stall) || (evt_valid && !evt_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("FAIL lcd_mode_timing_sequencer_core");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_output_backpressure();
        test_steady_stream(40);
        test_random_ticks(115);

        tick_valid <= 1'b0;
        while (pending_events.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (errors == 0)
            $display("PASS lcd_mode_timing_sequencer_core");
        else
            $display("FAIL lcd_mode_timing_sequencer_core");
        $finish;
    end

endmodule
